// ===== src/hcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcd_pkg: shared types and constants for the chunked stream decoder
// Item and result layouts, framing characters, status codes, hex decode.
// ----------------------------------------------------------------------------
package hcd_pkg;

    // One raw body byte from the link
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } hcd_in_item_t;

    // One decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_data;
        logic       out_done;
        logic [1:0] out_status;
    } hcd_out_item_t;

    // Queue status that gates input acceptance and drives the ports
    typedef struct packed {
        logic full;
        logic empty;
    } hcd_queue_status_t;

    // Close status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NODIGITS = 2'd1;
    localparam logic [1:0] STATUS_EARLY    = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    // Framing characters
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Trailer length (CR LF after the data bytes)
    localparam logic [1:0] TRAILER_LEN = 2'd2;

    // Hex digit decode: valid flag in bit 4, value in bits 3:0
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== src/hcd_parser.sv =====
// ----------------------------------------------------------------------------
// hcd_parser: front end of the chunked stream decoder
// Takes one byte per transfer, tracks the chunk framing, and emits at most one
// result entry per byte into the result queue.
// ----------------------------------------------------------------------------
module hcd_parser #(
    parameter int SIZE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  hcd_pkg::hcd_in_item_t  item,
    output logic                   wr_en,
    output hcd_pkg::hcd_out_item_t wr_data
);

    typedef enum logic [4:0] {
        PH_SIZE  = 5'b00001,
        PH_EXT   = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_TRAIL = 5'b01000,
        PH_ENDED = 5'b10000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   size_count_reg, size_count_next;
    logic                   digits_seen_reg, digits_seen_next;
    logic [1:0]             trailer_left_reg, trailer_left_next;

    logic [4:0]             hex;
    logic                   is_lf;
    logic                   size_top_busy;
    logic [SIZE_BITS-1:0]   size_dec;
    logic [1:0]             trailer_dec;
    logic                   data_flag;
    logic                   done_flag;
    logic [1:0]             status;
    logic                   was_ended;

    assign hex           = hcd_pkg::hex_decode(item.in_byte);
    assign is_lf         = (item.in_byte == hcd_pkg::CHAR_LF);
    assign size_top_busy = (size_count_reg[SIZE_BITS-1 -: 4] != 4'd0);
    assign size_dec      = (size_count_reg != '0) ? size_count_reg - 1'b1 : size_count_reg;
    assign trailer_dec   = (trailer_left_reg != 2'd0) ? trailer_left_reg - 2'd1
                                                      : trailer_left_reg;
    assign was_ended     = !(phase_reg == PH_SIZE || phase_reg == PH_EXT ||
                             phase_reg == PH_DATA || phase_reg == PH_TRAIL);

    // Framing state machine
    always_comb
    begin
        phase_next        = phase_reg;
        size_count_next   = size_count_reg;
        digits_seen_next  = digits_seen_reg;
        trailer_left_next = trailer_left_reg;
        data_flag         = 1'b0;
        done_flag         = 1'b0;
        status            = hcd_pkg::STATUS_OK;

        unique case (phase_reg)
            PH_SIZE:
            begin
                if (hex[4])
                begin
                    if (size_top_busy)
                    begin
                        done_flag  = 1'b1;
                        status     = hcd_pkg::STATUS_OVERFLOW;
                        phase_next = PH_ENDED;
                    end
                    else
                    begin
                        size_count_next  = {size_count_reg[SIZE_BITS-5:0], hex[3:0]};
                        digits_seen_next = 1'b1;
                    end
                end
                else if (!digits_seen_reg)
                begin
                    done_flag  = 1'b1;
                    status     = hcd_pkg::STATUS_NODIGITS;
                    phase_next = PH_ENDED;
                end
                else if (!is_lf)
                begin
                    phase_next = PH_EXT;
                end
                else if (size_count_reg == '0)
                begin
                    done_flag  = 1'b1;
                    status     = hcd_pkg::STATUS_OK;
                    phase_next = PH_ENDED;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_EXT:
            begin
                if (is_lf)
                begin
                    if (size_count_reg == '0)
                    begin
                        done_flag  = 1'b1;
                        status     = hcd_pkg::STATUS_OK;
                        phase_next = PH_ENDED;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                data_flag       = 1'b1;
                size_count_next = size_dec;
                if (size_dec == '0)
                begin
                    phase_next        = PH_TRAIL;
                    trailer_left_next = hcd_pkg::TRAILER_LEN;
                end
            end
            PH_TRAIL:
            begin
                trailer_left_next = trailer_dec;
                if (trailer_dec == 2'd0)
                begin
                    phase_next       = PH_SIZE;
                    size_count_next  = '0;
                    digits_seen_next = 1'b0;
                end
            end
            default:
            begin
                // ended phase and stray codes: drop the byte
            end
        endcase

        // Last byte of the message closes it if nothing else did
        if (item.in_last && !done_flag && !was_ended && phase_next != PH_ENDED)
        begin
            done_flag = 1'b1;
            if ((phase_next == PH_SIZE || phase_next == PH_EXT) &&
                digits_seen_next && size_count_next == '0)
            begin
                status = hcd_pkg::STATUS_OK;
            end
            else
            begin
                status = hcd_pkg::STATUS_EARLY;
            end
        end

        if (item.in_last)
        begin
            phase_next        = PH_SIZE;
            size_count_next   = '0;
            digits_seen_next  = 1'b0;
            trailer_left_next = 2'd0;
        end
    end

    // Result entry toward the queue
    assign wr_en              = accept && (data_flag || done_flag);
    assign wr_data.out_byte   = data_flag ? item.in_byte : 8'd0;
    assign wr_data.out_data   = data_flag;
    assign wr_data.out_done   = done_flag;
    assign wr_data.out_status = done_flag ? status : hcd_pkg::STATUS_OK;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SIZE;
            size_count_reg   <= '0;
            digits_seen_reg  <= 1'b0;
            trailer_left_reg <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            size_count_reg   <= size_count_next;
            digits_seen_reg  <= digits_seen_next;
            trailer_left_reg <= trailer_left_next;
        end
    end

endmodule

// ===== src/hcd_queue.sv =====
// ----------------------------------------------------------------------------
// hcd_queue: result queue between the parser and the result port
// Small register queue; the head entry is shown while not empty.
// ----------------------------------------------------------------------------
module hcd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  hcd_pkg::hcd_out_item_t    wr_data,
    input  logic                      rd_en,
    output hcd_pkg::hcd_out_item_t    rd_data,
    output hcd_pkg::hcd_queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hcd_pkg::hcd_out_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_wr, do_rd;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/http_chunked_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_stream_decoder: HTTP chunked body decoder
// Strips chunk size lines, extensions and trailers; passes data bytes and
// reports the close status of each message.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | item   : in_byte, in_last
//  result   | empty / pop        | result : out_byte, out_data, out_done,
//           |                    |          out_status
//
//  One byte per cycle is taken while full is low; its result, if any, is
//  visible the next cycle. full rises only when the result queue holds
//  QUEUE_DEPTH entries. The parser stalls only on full; pop with push keeps
//  the full one-byte-per-cycle rate with any queue depth of two or more.
//  Reset (rst_n low) empties the queue and returns the parser to a size line.
// ----------------------------------------------------------------------------
module http_chunked_stream_decoder #(
    parameter int SIZE_BITS   = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  hcd_pkg::hcd_in_item_t  item,
    output logic                   empty,
    input  logic                   pop,
    output hcd_pkg::hcd_out_item_t result
);

    logic                       accept;
    logic                       wr_en;
    hcd_pkg::hcd_out_item_t     wr_data;
    hcd_pkg::hcd_queue_status_t q_status;

    assign accept = push && !q_status.full;
    assign full   = q_status.full;
    assign empty  = q_status.empty;

    // Front end: framing parser
    hcd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    // Back end: result queue
    hcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_en   (pop),
        .rd_data (result),
        .status  (q_status)
    );

    // Checks
    a_not_full_and_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue reports full and empty");

    a_write_shows_result : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !empty)
        else $error("written result not visible");

    a_pop_frees_space : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !wr_en) |=> !full)
        else $error("queue full after pop without write");

    a_entry_meaningful : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_data.out_data || wr_data.out_done))
        else $error("empty result entry written");

endmodule
